// File: design/spse_pkg.sv
// Shared constants, types and helpers for the symmetric pivot swap engine.
`timescale 1ns / 1ps

package spse_pkg;

	// Built dimension and derived widths
	localparam int MAX_DIM = 64;
	localparam int IDX_W   = $clog2(MAX_DIM);
	localparam int CNT_W   = $clog2(MAX_DIM + 1);
	localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
	localparam int ELEM_W  = 64;
	localparam int SIGN_W  = 2;
	localparam int FUNC_W  = 3;
	localparam int ACT_W   = 7;

	// Input beat layout
	localparam int IN_ROW_LSB  = 0;
	localparam int IN_COL_LSB  = IN_ROW_LSB + IDX_W;
	localparam int IN_ELEM_LSB = IN_COL_LSB + IDX_W;
	localparam int IN_SIGN_LSB = IN_ELEM_LSB + ELEM_W;
	localparam int IN_DATA_W   = ((IN_SIGN_LSB + SIGN_W + 7) / 8) * 8;

	// Output beat layout
	localparam int OUT_ELEM_LSB = 0;
	localparam int OUT_SIGN_LSB = OUT_ELEM_LSB + ELEM_W;
	localparam int OUT_REC_LSB  = OUT_SIGN_LSB + SIGN_W;
	localparam int OUT_DATA_W   = ((OUT_REC_LSB + IDX_W + 7) / 8) * 8;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = ACT_W;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIANGLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 2'd1;

	// Item function codes
	localparam logic [FUNC_W-1:0] FN_WR_ELEM = 3'd0;
	localparam logic [FUNC_W-1:0] FN_RD_ELEM = 3'd1;
	localparam logic [FUNC_W-1:0] FN_WR_SIGN = 3'd2;
	localparam logic [FUNC_W-1:0] FN_RD_SIGN = 3'd3;
	localparam logic [FUNC_W-1:0] FN_WR_REC  = 3'd4;
	localparam logic [FUNC_W-1:0] FN_RD_REC  = 3'd5;
	localparam logic [FUNC_W-1:0] FN_SWAP    = 3'd6;
	localparam logic [FUNC_W-1:0] FN_NOP     = 3'd7;

	localparam logic signed [SIGN_W-1:0] SIGN_RESET = 2'sb01;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// Command into the sign / record store
	typedef struct packed {
		logic                     vld;
		logic [FUNC_W-1:0]        func;
		idx_t                     a;
		idx_t                     b;
		logic signed [SIGN_W-1:0] sign;
	} vec_cmd_t;

	// Read data and status back from the sign / record store
	typedef struct packed {
		logic                     busy;
		logic signed [SIGN_W-1:0] sign;
		idx_t                     rec;
	} vec_rsp_t;

	// Read requests from the swap walker
	typedef struct packed {
		logic  busy;
		logic  rd;
		logic  half;
		addr_t addr;
	} walk_t;

	// Column-major position of (row, col)
	function automatic addr_t elem_addr(input idx_t r, input idx_t c);
		elem_addr = ADDR_W'(r) + ADDR_W'(c) * ADDR_W'(MAX_DIM);
	endfunction

endpackage

// File: design/spse_vec_store.sv
// Pivot sign and swap record memories with reset-valid bits and the sign exchange sequence.
`timescale 1ns / 1ps

module spse_vec_store (
	input  logic              clk,
	input  logic              arst_n,
	input  spse_pkg::vec_cmd_t cmd,
	output spse_pkg::vec_rsp_t rsp
);
	import spse_pkg::*;

	localparam logic [1:0] VS_IDLE = 2'd0;
	localparam logic [1:0] VS_RDB  = 2'd1;
	localparam logic [1:0] VS_WRA  = 2'd2;
	localparam logic [1:0] VS_WRB  = 2'd3;

	logic signed [SIGN_W-1:0] sgn_mem [MAX_DIM];
	idx_t                     rec_mem [MAX_DIM];
	logic [MAX_DIM-1:0]       sgn_vld_q;
	logic [MAX_DIM-1:0]       rec_vld_q;

	logic [1:0]               step_q;
	idx_t                     a_q;
	idx_t                     b_q;
	logic signed [SIGN_W-1:0] sa_q;

	idx_t                     raddr;
	logic signed [SIGN_W-1:0] sgn_rd_q;
	idx_t                     rec_rd_q;
	logic                     sgn_rv_q;
	logic                     rec_rv_q;
	idx_t                     ra_q;
	logic signed [SIGN_W-1:0] sgn_out;

	logic                     sgn_we;
	idx_t                     sgn_wa;
	logic signed [SIGN_W-1:0] sgn_wd;
	logic                     rec_we;
	idx_t                     rec_wa;
	idx_t                     rec_wd;

	logic cmd_swap;

	assign cmd_swap = cmd.vld && (cmd.func == FN_SWAP) && (step_q == VS_IDLE);

	// Entries never written read as their reset value
	assign sgn_out = sgn_rv_q ? sgn_rd_q : SIGN_RESET;

	// Read address: second sign of an exchange, else the command index
	assign raddr = (step_q == VS_RDB) ? b_q : cmd.a;

	// Write port selection
	always_comb begin
		sgn_we = 1'b0;
		sgn_wa = cmd.a;
		sgn_wd = cmd.sign;
		rec_we = 1'b0;
		rec_wa = cmd.a;
		rec_wd = cmd.b;
		unique case (step_q)
			VS_WRA: begin
				sgn_we = 1'b1;
				sgn_wa = a_q;
				sgn_wd = sgn_out;
			end
			VS_WRB: begin
				sgn_we = 1'b1;
				sgn_wa = b_q;
				sgn_wd = sa_q;
			end
			default: begin
				sgn_we = cmd.vld && (cmd.func == FN_WR_SIGN);
				rec_we = cmd.vld && ((cmd.func == FN_WR_REC) || (cmd.func == FN_SWAP));
			end
		endcase
	end

	// Memories
	always_ff @(posedge clk) begin
		if (sgn_we) begin
			sgn_mem[sgn_wa] <= sgn_wd;
		end
		if (rec_we) begin
			rec_mem[rec_wa] <= rec_wd;
		end
		sgn_rd_q <= sgn_mem[raddr];
		rec_rd_q <= rec_mem[raddr];
		ra_q     <= raddr;
	end

	// Valid bits and their registered lookup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sgn_vld_q <= '0;
			rec_vld_q <= '0;
			sgn_rv_q  <= 1'b0;
			rec_rv_q  <= 1'b0;
		end else begin
			if (sgn_we) begin
				sgn_vld_q[sgn_wa] <= 1'b1;
			end
			if (rec_we) begin
				rec_vld_q[rec_wa] <= 1'b1;
			end
			sgn_rv_q <= sgn_vld_q[raddr];
			rec_rv_q <= rec_vld_q[raddr];
		end
	end

	// Sign exchange sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= VS_IDLE;
		end else begin
			unique case (step_q)
				VS_IDLE: if (cmd_swap) begin
					step_q <= VS_RDB;
				end
				VS_RDB:  step_q <= VS_WRA;
				VS_WRA:  step_q <= VS_WRB;
				VS_WRB:  step_q <= VS_IDLE;
				default: step_q <= VS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_swap) begin
			a_q <= cmd.a;
			b_q <= cmd.b;
		end
		if (step_q == VS_RDB) begin
			sa_q <= sgn_out;
		end
	end

	assign rsp.busy = (step_q != VS_IDLE);
	assign rsp.sign = sgn_out;
	assign rsp.rec  = rec_rv_q ? rec_rd_q : ra_q;

endmodule

// File: design/spse_swap_walk.sv
// Address walker that lists the element pairs of one symmetric interchange.
`timescale 1ns / 1ps

module spse_swap_walk (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  spse_pkg::idx_t  idx_lo,
	input  spse_pkg::idx_t  idx_hi,
	input  logic [spse_pkg::CNT_W-1:0] order,
	input  logic            tri_upper,
	output spse_pkg::walk_t walk
);
	import spse_pkg::*;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_DIAG = 3'd1;
	localparam logic [2:0] PH_SEG1 = 3'd2;
	localparam logic [2:0] PH_SEG2 = 3'd3;
	localparam logic [2:0] PH_SEG3 = 3'd4;

	logic [2:0]       ph_q;
	logic [CNT_W-1:0] k_q;
	logic             half_q;
	idx_t             i_q;
	idx_t             j_q;
	logic [CNT_W-1:0] n_q;
	logic             tri_q;

	logic [CNT_W-1:0] seg_end;
	logic             in_rng;
	idx_t             k;
	addr_t            a_addr;
	addr_t            b_addr;

	assign k = k_q[IDX_W-1:0];

	// Segment bound and pair addresses for the current step
	always_comb begin
		seg_end = n_q;
		a_addr  = elem_addr(i_q, i_q);
		b_addr  = elem_addr(j_q, j_q);
		unique case (ph_q)
			PH_SEG1: begin
				seg_end = CNT_W'(i_q);
				a_addr  = tri_q ? elem_addr(k, i_q) : elem_addr(i_q, k);
				b_addr  = tri_q ? elem_addr(k, j_q) : elem_addr(j_q, k);
			end
			PH_SEG2: begin
				seg_end = n_q;
				a_addr  = tri_q ? elem_addr(i_q, k) : elem_addr(k, i_q);
				b_addr  = tri_q ? elem_addr(j_q, k) : elem_addr(k, j_q);
			end
			PH_SEG3: begin
				seg_end = CNT_W'(j_q);
				a_addr  = tri_q ? elem_addr(i_q, k) : elem_addr(k, i_q);
				b_addr  = tri_q ? elem_addr(k, j_q) : elem_addr(j_q, k);
			end
			default: begin
				seg_end = n_q;
			end
		endcase
		in_rng = (ph_q == PH_DIAG) ||
			(((ph_q == PH_SEG1) || (ph_q == PH_SEG2) || (ph_q == PH_SEG3)) &&
			(k_q < seg_end));
	end

	// Phase and step counter; an empty segment still passes through one idle step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			k_q    <= '0;
			half_q <= 1'b0;
		end else if (start) begin
			ph_q   <= PH_DIAG;
			k_q    <= '0;
			half_q <= 1'b0;
		end else if (in_rng) begin
			half_q <= ~half_q;
			if (half_q) begin
				if (ph_q == PH_DIAG) begin
					ph_q <= PH_SEG1;
					k_q  <= '0;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
		end else begin
			unique case (ph_q)
				PH_SEG1: begin
					ph_q <= PH_SEG2;
					k_q  <= CNT_W'(j_q) + 1'b1;
				end
				PH_SEG2: begin
					ph_q <= PH_SEG3;
					k_q  <= CNT_W'(i_q) + 1'b1;
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			i_q   <= idx_lo;
			j_q   <= idx_hi;
			n_q   <= order;
			tri_q <= tri_upper;
		end
	end

	assign walk.busy = (ph_q != PH_IDLE);
	assign walk.rd   = in_rng;
	assign walk.half = half_q;
	assign walk.addr = half_q ? b_addr : a_addr;

endmodule

// File: design/symmetric_pivot_swap_engine.sv
// Symmetric pivot swap engine: top level with matrix memory, item sequencer and result register.
`timescale 1ns / 1ps

// Holds a symmetric matrix of order up to MAX_DIM in one triangle of a column-major
// memory (one write and one registered read per cycle), plus a pivot sign and a swap
// record per index. One item is worked at a time; a new beat is taken while the last
// result still sits in the output register. A swap of distinct indices moves n-1
// element pairs through the matrix memory, n being the active order (one read each
// side, writes trail behind), plus one closing step per off-diagonal segment.
// Writes, out-of-range items and equal swap indices go straight to the result state;
// reads pass through a read state first.
module symmetric_pivot_swap_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// row_index[5:0], col_index[11:6], element_bits[75:12], sign_value[77:76], zero fill
	input  logic [spse_pkg::IN_DATA_W-1:0]  s_tdata,
	// func[2:0]
	input  logic [spse_pkg::FUNC_W-1:0]     s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// read_element[63:0], read_sign[65:64], read_record[71:66]
	output logic [spse_pkg::OUT_DATA_W-1:0] m_tdata,
	// status[0]
	output logic [0:0]                      m_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [spse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spse_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import spse_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_SWAP = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	// Configuration
	logic             tri_q;
	logic [ACT_W-1:0] active_q;
	logic [CNT_W-1:0] n_eff;

	// Item decode
	logic [FUNC_W-1:0]        func;
	idx_t                     row;
	idx_t                     col;
	logic [ELEM_W-1:0]        elem;
	logic signed [SIGN_W-1:0] sign;
	logic                     acc;
	logic                     need_col;
	logic                     oor;
	logic                     go;
	logic                     is_swap;
	logic                     same_idx;
	idx_t                     idx_lo;
	idx_t                     idx_hi;

	// Sequencer and result
	logic [1:0]               state_q;
	logic [FUNC_W-1:0]        func_q;
	logic [ELEM_W-1:0]        res_elem_q;
	logic signed [SIGN_W-1:0] res_sign_q;
	idx_t                     res_rec_q;
	logic                     res_st_q;
	logic                     out_free;
	logic                     m_valid_q;
	logic [OUT_DATA_W-1:0]    m_data_q;
	logic                     m_user_q;
	logic                     swap_done;

	// Matrix memory and swap pipeline
	logic [ELEM_W-1:0] mat_mem [MAX_DIM * MAX_DIM];
	logic [ELEM_W-1:0] mat_rd_q;
	addr_t             mat_ra;
	logic              mat_we;
	addr_t             mat_wa;
	logic [ELEM_W-1:0] mat_wd;

	logic              sw_vld_s1;
	logic              sw_half_s1;
	addr_t             sw_addr_s1;
	addr_t             a_addr_q;
	logic [ELEM_W-1:0] a_val_q;
	logic              pend_q;
	addr_t             pend_addr_q;
	logic [ELEM_W-1:0] pend_val_q;

	vec_cmd_t vcmd;
	vec_rsp_t vrsp;
	walk_t    walk;

	// Field extraction
	assign func = s_tuser;
	assign row  = s_tdata[IN_ROW_LSB +: IDX_W];
	assign col  = s_tdata[IN_COL_LSB +: IDX_W];
	assign elem = s_tdata[IN_ELEM_LSB +: ELEM_W];
	assign sign = s_tdata[IN_SIGN_LSB +: SIGN_W];

	// Configuration writes, always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_q    <= 1'b0;
			active_q <= ACT_W'(MAX_DIM);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_TRIANGLE) begin
				tri_q <= cfg_data[0];
			end else if (cfg_index == CFG_ACTIVE) begin
				active_q <= cfg_data;
			end
		end
	end

	assign n_eff = (32'(active_q) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(active_q);

	// Range check and dispatch
	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign need_col = (func == FN_WR_ELEM) || (func == FN_RD_ELEM) ||
		(func == FN_WR_REC) || (func == FN_SWAP);
	assign oor      = (func != FN_NOP) &&
		((CNT_W'(row) >= n_eff) || (need_col && (CNT_W'(col) >= n_eff)));
	assign go       = acc && !oor;
	assign is_swap  = (func == FN_SWAP);
	assign same_idx = (row == col);
	assign idx_lo   = (row < col) ? row : col;
	assign idx_hi   = (row < col) ? col : row;

	assign vcmd.vld  = go && ((func == FN_WR_SIGN) || (func == FN_RD_SIGN) ||
		(func == FN_WR_REC) || (func == FN_RD_REC) || (is_swap && !same_idx));
	assign vcmd.func = func;
	assign vcmd.a    = is_swap ? idx_lo : row;
	assign vcmd.b    = is_swap ? idx_hi : col;
	assign vcmd.sign = sign;

	spse_vec_store u_vec (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (vcmd),
		.rsp    (vrsp)
	);

	spse_swap_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (go && is_swap && !same_idx),
		.idx_lo    (idx_lo),
		.idx_hi    (idx_hi),
		.order     (n_eff),
		.tri_upper (tri_q),
		.walk      (walk)
	);

	// Matrix port selection
	assign mat_ra = walk.rd ? walk.addr : elem_addr(row, col);

	always_comb begin
		mat_we = 1'b0;
		mat_wa = elem_addr(row, col);
		mat_wd = elem;
		if (sw_vld_s1 && sw_half_s1) begin
			mat_we = 1'b1;
			mat_wa = a_addr_q;
			mat_wd = mat_rd_q;
		end else if (pend_q) begin
			mat_we = 1'b1;
			mat_wa = pend_addr_q;
			mat_wd = pend_val_q;
		end else if (go && (func == FN_WR_ELEM)) begin
			mat_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mat_we) begin
			mat_mem[mat_wa] <= mat_wd;
		end
		mat_rd_q <= mat_mem[mat_ra];
	end

	// Swap pipeline: first word of a pair is held, second word lands on the first
	// address, then the held word goes to the second address in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_vld_s1 <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			sw_vld_s1 <= walk.rd;
			if (sw_vld_s1 && sw_half_s1) begin
				pend_q <= 1'b1;
			end else if (pend_q) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		sw_half_s1 <= walk.half;
		sw_addr_s1 <= walk.addr;
		if (sw_vld_s1 && !sw_half_s1) begin
			a_addr_q <= sw_addr_s1;
			a_val_q  <= mat_rd_q;
		end
		if (sw_vld_s1 && sw_half_s1) begin
			pend_addr_q <= sw_addr_s1;
			pend_val_q  <= a_val_q;
		end
	end

	assign swap_done = !walk.busy && !sw_vld_s1 && !pend_q && !vrsp.busy;

	// Item sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (acc) begin
					priority if (oor) begin
						state_q <= ST_FIN;
					end else if ((func == FN_RD_ELEM) || (func == FN_RD_SIGN) ||
						(func == FN_RD_REC)) begin
						state_q <= ST_RD;
					end else if (is_swap && !same_idx) begin
						state_q <= ST_SWAP;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_RD:   state_q <= ST_FIN;
				ST_SWAP: if (swap_done) begin
					state_q <= ST_FIN;
				end
				ST_FIN:  if (out_free) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result fields
	always_ff @(posedge clk) begin
		if (acc) begin
			func_q     <= func;
			res_elem_q <= '0;
			res_sign_q <= '0;
			res_rec_q  <= '0;
			res_st_q   <= oor;
		end else if (state_q == ST_RD) begin
			if (func_q == FN_RD_ELEM) begin
				res_elem_q <= mat_rd_q;
			end
			if (func_q == FN_RD_SIGN) begin
				res_sign_q <= vrsp.sign;
			end
			if (func_q == FN_RD_REC) begin
				res_rec_q <= vrsp.rec;
			end
		end
	end

	// Output register
	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			m_data_q <= '0;
			m_data_q[OUT_ELEM_LSB +: ELEM_W] <= res_elem_q;
			m_data_q[OUT_SIGN_LSB +: SIGN_W] <= res_sign_q;
			m_data_q[OUT_REC_LSB +: IDX_W]   <= res_rec_q;
			m_user_q <= res_st_q;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_user_q;

endmodule

// File: design/spse_checker.sv
// Port-level checker for the symmetric pivot swap engine, bound to the top level.
`timescale 1ns / 1ps

module spse_port_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [spse_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [0:0]                      m_tuser
);
	import spse_pkg::*;

	// Items taken but not yet delivered
	logic [1:0] cnt_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_beat && !out_beat) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (out_beat && !in_beat) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// No result without a taken item
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (cnt_q != 2'd0))
		else $error("result beat with no item outstanding");

	// One item in work plus one result waiting at most
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd3))
		else $error("too many items outstanding");

	// An ignored item reads back nothing
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == '0))
		else $error("ignored item returned data");

	// At most one read field carries data
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($countones({|m_tdata[OUT_ELEM_LSB +: ELEM_W],
			|m_tdata[OUT_SIGN_LSB +: SIGN_W], |m_tdata[OUT_REC_LSB +: IDX_W]}) <= 1))
		else $error("more than one read field set");

endmodule

bind symmetric_pivot_swap_engine spse_port_checker u_spse_port_checker (.*);
